// ===== design/qfe_pkg.sv =====
// Shared types and constants for the quadratic feature expansion block.
// Used by the controller, the datapath and the top level.
package qfe_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int PRODUCT_W       = 32;
	localparam int INDEX_W         = 12;
	localparam int IN_TDATA_W      = 16;
	localparam int OUT_TDATA_W     = 48;
	localparam int OUT_PAD_W       = OUT_TDATA_W - PRODUCT_W - INDEX_W;
	localparam int DEF_MAX_LEN     = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	typedef struct packed {
		logic               store;
		logic               issue;
		logic               last;
		logic               ovf;
		logic [INDEX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic advance;
		logic empty;
	} sts_t;

endpackage

// ===== design/qfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/qfe_datapath.sv =====
// Datapath: element store, read/multiply pipeline and output beat register.
// Depends on qfe_pkg and qfe_ram.
module qfe_datapath #(
	parameter int MAX_LEN     = qfe_pkg::DEF_MAX_LEN,
	parameter int SAMPLE_BITS = qfe_pkg::DEF_SAMPLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [qfe_pkg::SAMPLE_W-1:0] sample,
	input  qfe_pkg::cmd_t                cmd,
	input  logic [$clog2(MAX_LEN)-1:0]   wr_addr,
	input  logic [$clog2(MAX_LEN)-1:0]   rd_addr,
	output qfe_pkg::sts_t                sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [qfe_pkg::PRODUCT_W-1:0] out_product,
	output logic [qfe_pkg::INDEX_W-1:0]  out_index,
	output logic                         out_last,
	output logic                         out_ovf
);
	import qfe_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	logic                          advance;
	logic [AW-1:0]                 raddr;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic [SAMPLE_BITS-1:0]        x_wr;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [2*SAMPLE_BITS-1:0] mult;

	logic               v_s1, last_s1, ovf_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [AW-1:0]      addr_s1;

	logic                 v_s2, last_s2, ovf_s2;
	logic [INDEX_W-1:0]   idx_s2;
	logic [PRODUCT_W-1:0] product_s2;

	logic                 valid_q, last_q, ovf_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [PRODUCT_W-1:0] product_q;

	assign advance     = !valid_q || out_ready;
	assign sts.advance = advance;
	assign sts.empty   = !v_s1 && !v_s2;

	assign x_wr  = SAMPLE_BITS'(sample);
	assign raddr = advance ? rd_addr : addr_s1;
	assign mult  = $signed(rd_data) * x_q;

	qfe_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_LEN)
	) u_store (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (wr_addr),
		.wdata (x_wr),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			x_q <= x_wr;
		end
		if (advance) begin
			idx_s1     <= cmd.idx;
			last_s1    <= cmd.last;
			ovf_s1     <= cmd.ovf;
			addr_s1    <= rd_addr;
			idx_s2     <= idx_s1;
			last_s2    <= last_s1;
			ovf_s2     <= ovf_s1;
			product_s2 <= ovf_s1 ? '0 : PRODUCT_W'(mult);
			idx_q      <= idx_s2;
			last_q     <= last_s2;
			ovf_q      <= ovf_s2;
			product_q  <= product_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	assign out_valid   = valid_q;
	assign out_product = product_q;
	assign out_index   = idx_q;
	assign out_last    = last_q;
	assign out_ovf     = ovf_q;

	a_ovf_beat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && ovf_q |-> last_q && product_q == '0)
		else $error("overflow beat without last or with nonzero product");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !advance |=> v_s2 && $stable(product_s2))
		else $error("product stage changed during stall");

	a_store_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !v_s1 && !v_s2)
		else $error("element stored while pipeline busy");

endmodule

// ===== design/qfe_ctrl.sv =====
// Controller: sequences one row of products per element, or one overflow
// beat when full; tracks count and index. Depends on qfe_pkg.
module qfe_ctrl #(
	parameter int MAX_LEN = qfe_pkg::DEF_MAX_LEN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_final,
	output logic                       in_ready,
	input  qfe_pkg::sts_t              sts,
	output qfe_pkg::cmd_t              cmd,
	output logic [$clog2(MAX_LEN)-1:0] wr_addr,
	output logic [$clog2(MAX_LEN)-1:0] rd_addr
);
	import qfe_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_OVF   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [INDEX_W-1:0] tri_q;
	logic [AW-1:0]      i_q, j_q;
	logic               final_q;
	logic               accept, full, row_end;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_LEN));
	assign row_end  = (j_q == i_q);
	assign wr_addr  = count_q[AW-1:0];
	assign rd_addr  = j_q;

	always_comb begin
		cmd       = '0;
		cmd.store = accept && !full;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				cmd.last  = row_end;
				cmd.idx   = tri_q + INDEX_W'(j_q);
			end
			ST_OVF: begin
				cmd.issue = 1'b1;
				cmd.last  = 1'b1;
				cmd.ovf   = 1'b1;
				cmd.idx   = tri_q;
			end
			ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			tri_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						final_q <= in_final;
						if (full) begin
							state_q <= ST_OVF;
						end else begin
							i_q     <= count_q[AW-1:0];
							j_q     <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (sts.advance) begin
						if (row_end) begin
							count_q <= final_q ? '0 : CW'(i_q) + CW'(1);
							tri_q   <= final_q ? '0 : tri_q + INDEX_W'(i_q) + INDEX_W'(1);
							state_q <= ST_DRAIN;
						end else begin
							j_q <= j_q + AW'(1);
						end
					end
				end
				ST_OVF: begin
					if (sts.advance) begin
						if (final_q) begin
							count_q <= '0;
							tri_q   <= '0;
						end
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.empty) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_full_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full |=> state_q == ST_OVF)
		else $error("element beyond capacity did not take overflow path");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> j_q <= i_q)
		else $error("column counter ran past row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> sts.empty)
		else $error("idle with products still in flight");

endmodule

// ===== design/quadratic_feature_expand_unit.sv =====
// Top level of the quadratic feature expansion block.
// Depends on qfe_pkg, qfe_ctrl, qfe_datapath and qfe_ram.
//
// Usage: each slave beat carries one vector element (s_tdata) and a final
// flag (s_tuser). Element i is written to the element store and then row i
// of the lower triangle of the outer product is sent out, x[i]*x[j] for
// j = 0..i, one master beat per product, with its triangular index. m_tlast
// marks the last product of the row; m_tuser flags an element past capacity,
// which yields one beat with product zero and is otherwise dropped.
// After a slave beat is accepted, its row's products pass the s1 and s2 registers into the output register.
// Without stalls, element i is accepted in idle, then issues i + 1 reads from
// the store's single read port, then waits in drain until the read/multiply
// pipeline is empty and returns to idle; an overflowed element issues one
// overflow beat instead of the reads.
// A stall on the master side holds the whole read/multiply pipeline; s_tready
// stays low until the row has left the pipeline, and the next element is
// taken while the final product still waits in the output register.
// Reset clears the element count, the index and all valid flags; the store
// itself is not cleared.
module quadratic_feature_expand_unit #(
	parameter int MAX_LEN     = qfe_pkg::DEF_MAX_LEN,
	parameter int SAMPLE_BITS = qfe_pkg::DEF_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [qfe_pkg::IN_TDATA_W-1:0] s_tdata,   // [15:0] sample
	input  logic [0:0]                     s_tuser,   // [0] final_element
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [qfe_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] product, [43:32] out_index
	output logic                           m_tlast,   // run_last
	output logic [0:0]                     m_tuser    // [0] overflow
);
	import qfe_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	cmd_t                 cmd;
	sts_t                 sts;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [PRODUCT_W-1:0] product;
	logic [INDEX_W-1:0]   out_index;

	qfe_ctrl #(
		.MAX_LEN (MAX_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_final (s_tuser[0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	qfe_datapath #(
		.MAX_LEN     (MAX_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (s_tdata[SAMPLE_W-1:0]),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_product (product),
		.out_index   (out_index),
		.out_last    (m_tlast),
		.out_ovf     (m_tuser[0])
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_index, product};

endmodule
